// ===== src/wgp_pkg.sv =====
`default_nettype none
package wgp_pkg;

  localparam int MAX_DEPTH = 8;
  localparam int LVW = (MAX_DEPTH > 1) ? $clog2(MAX_DEPTH) : 1;

  localparam logic [31:0] L1000 = 32'd1000;
  localparam logic [31:0] L2000 = 32'd2000;
  localparam logic [31:0] L3000 = 32'd3000;
  localparam logic [31:0] L4000 = 32'd4000;
  localparam logic [31:0] SIGN_BIT = 32'h8000_0000;
  localparam logic [31:0] LOW_MASK = 32'h0000_00ff;

  localparam logic [3:0] GT_POINT  = 4'd1;
  localparam logic [3:0] GT_LINE   = 4'd2;
  localparam logic [3:0] GT_POLY   = 4'd3;
  localparam logic [3:0] GT_MPOINT = 4'd4;
  localparam logic [3:0] GT_MLINE  = 4'd5;
  localparam logic [3:0] GT_MPOLY  = 4'd6;
  localparam logic [3:0] GT_COLL   = 4'd7;
  localparam logic [3:0] GT_CSTR   = 4'd8;
  localparam logic [3:0] GT_CCURVE = 4'd9;
  localparam logic [3:0] GT_CPOLY  = 4'd10;
  localparam logic [3:0] GT_RING   = 4'd11;

  localparam logic CFG_ALT_DIALECT = 1'b0;
  localparam logic CFG_ALT_LE      = 1'b1;

  typedef enum logic [2:0] {
    EV_BEGIN = 3'd0,
    EV_POINT = 3'd1,
    EV_END   = 3'd2,
    EV_DONE  = 3'd3,
    EV_ERROR = 3'd4
  } ev_t;

  typedef enum logic [2:0] {
    ERR_TRUNC    = 3'd0,
    ERR_LAYOUT   = 3'd1,
    ERR_TYPE     = 3'd2,
    ERR_CHILD    = 3'd3,
    ERR_MISMATCH = 3'd4,
    ERR_DEPTH    = 3'd5,
    ERR_ARC      = 3'd6
  } err_t;

  typedef enum logic [4:0] {
    S_ROOT_ORDER,
    S_ROOT_TYPE,
    S_CHILD_ORDER,
    S_CHILD_TYPE,
    S_COUNT,
    S_RING_COUNT,
    S_ORD,
    S_DONE,
    S_ERR,
    S_HDR_ROOT,
    S_HDR_CHILD,
    S_CNT,
    S_RCNT,
    S_RZERO,
    S_PT,
    S_FIN,
    S_DONE_EV,
    S_MARK
  } st_t;

  typedef enum logic [3:0] {
    OP_NONE,
    OP_ORDER,
    OP_TAKE,
    OP_REARM,
    OP_HDR_ROOT,
    OP_HDR_CHILD,
    OP_CNT,
    OP_RCNT,
    OP_RZERO,
    OP_PT,
    OP_FIN,
    OP_DONE,
    OP_MARK
  } op_t;

  typedef struct packed {
    logic fire;
    op_t  op;
    logic emit;
    ev_t  ev;
    err_t err;
    logic last;
  } cmd_t;

  typedef struct packed {
    logic       out_free;
    logic       bi3;
    logic       bi7;
    logic       lay_bad;
    logic       type_bad;
    logic       base_point;
    logic       child_bad;
    logic       mismatch;
    logic       depth_bad;
    logic       cnt_zero;
    logic       arc_bad;
    logic       lvl_zero;
    logic       left_dec_zero;
    logic       pts_dec_zero;
    logic       ord_last;
    logic       all_nan;
    logic [3:0] cur_type;
  } sts_t;

  function automatic logic child_ok(input logic [3:0] parent, input logic [3:0] c);
    logic ok;
    case (parent)
      GT_MPOINT: ok = (c == GT_POINT);
      GT_MLINE:  ok = (c == GT_LINE);
      GT_MPOLY:  ok = (c == GT_POLY);
      GT_COLL:   ok = 1'b1;
      GT_CCURVE: ok = (c == GT_CSTR) || (c == GT_LINE);
      GT_CPOLY:  ok = (c == GT_CSTR) || (c == GT_LINE) || (c == GT_CCURVE);
      default:   ok = 1'b0;
    endcase
    return ok;
  endfunction

  function automatic logic is_nan(input logic [63:0] v);
    return (v[62:52] == 11'h7ff) && (v[51:0] != 52'd0);
  endfunction

endpackage
`default_nettype wire

// ===== src/wkb_geometry_stream_parser.sv =====
`default_nettype none
// Byte-stream parser for binary geometries.
// Input channel: one transaction per stream byte (kind 0) or end marker
// (kind 1), handshake item_valid / item_stall.
// Output channel: one transaction per event (begin, point, end, done, error),
// handshake res_valid / res_stall, last set on the final event of a byte.
// A data byte that completes no field is taken without a stall. A byte that
// completes a type word, count or ordinate adds an evaluation state, and
// every event takes a state in the controller; a byte closing nested
// geometries holds the input longer. The event count and the single
// output register set how long.
// The first event is loaded into the output register once the controller has evaluated the byte that completes it.
// Reset clears the controller, the output valid flag and both config bits;
// the parser then waits for a root order byte.
// While res_stall is high the pending event holds and item_stall rises
// once the controller has another event to write.
// Config writes (cfg_we, cfg_index, cfg_data) are registered and take effect at the next order byte.
module wkb_geometry_stream_parser (
  input  wire logic        clk,
  input  wire logic        rst,
  input  wire logic        item_valid,
  output logic             item_stall,
  input  wire logic        kind,
  input  wire logic [7:0]  data_byte,
  output logic             res_valid,
  input  wire logic        res_stall,
  output logic [2:0]       event_res,
  output logic [3:0]       geometry_type,
  output logic [1:0]       coord_layout,
  output logic [3:0]       nesting_level,
  output logic [63:0]      ord_x,
  output logic [63:0]      ord_y,
  output logic [63:0]      ord_third,
  output logic [63:0]      ord_fourth,
  output logic [2:0]       error_code,
  output logic             last,
  input  wire logic        cfg_we,
  input  wire logic        cfg_index,
  input  wire logic        cfg_data
);

  wgp_pkg::cmd_t cmd;
  wgp_pkg::sts_t sts;

  wgp_ctrl u_ctrl (
    .clk        (clk),
    .rst        (rst),
    .item_valid (item_valid),
    .kind       (kind),
    .item_stall (item_stall),
    .sts        (sts),
    .cmd        (cmd)
  );

  wgp_dp u_dp (
    .clk           (clk),
    .rst           (rst),
    .cmd           (cmd),
    .sts           (sts),
    .data_byte     (data_byte),
    .cfg_we        (cfg_we),
    .cfg_index     (cfg_index),
    .cfg_data      (cfg_data),
    .res_valid     (res_valid),
    .res_stall     (res_stall),
    .event_res     (event_res),
    .geometry_type (geometry_type),
    .coord_layout  (coord_layout),
    .nesting_level (nesting_level),
    .ord_x         (ord_x),
    .ord_y         (ord_y),
    .ord_third     (ord_third),
    .ord_fourth    (ord_fourth),
    .error_code    (error_code),
    .last          (last)
  );

endmodule
`default_nettype wire

// ===== src/wgp_ctrl.sv =====
`default_nettype none
module wgp_ctrl (
  input  wire logic          clk,
  input  wire logic          rst,
  input  wire logic          item_valid,
  input  wire logic          kind,
  output logic               item_stall,
  input  wire wgp_pkg::sts_t sts,
  output wgp_pkg::cmd_t      cmd
);

  wgp_pkg::st_t state, state_next;
  logic phase;
  logic acc;

  assign phase = state inside {wgp_pkg::S_ROOT_ORDER, wgp_pkg::S_ROOT_TYPE,
                               wgp_pkg::S_CHILD_ORDER, wgp_pkg::S_CHILD_TYPE,
                               wgp_pkg::S_COUNT, wgp_pkg::S_RING_COUNT,
                               wgp_pkg::S_ORD, wgp_pkg::S_DONE, wgp_pkg::S_ERR};
  assign item_stall = !phase;
  assign acc = item_valid && phase;

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= wgp_pkg::S_ROOT_ORDER;
    end else begin
      state <= state_next;
    end
  end

  // next state
  always_comb begin
    state_next = state;
    case (state)
      wgp_pkg::S_ROOT_ORDER: begin
        if (acc) state_next = kind ? wgp_pkg::S_MARK : wgp_pkg::S_ROOT_TYPE;
      end
      wgp_pkg::S_CHILD_ORDER: begin
        if (acc) state_next = kind ? wgp_pkg::S_MARK : wgp_pkg::S_CHILD_TYPE;
      end
      wgp_pkg::S_ROOT_TYPE: begin
        if (acc) begin
          if (kind) state_next = wgp_pkg::S_MARK;
          else if (sts.bi3) state_next = wgp_pkg::S_HDR_ROOT;
        end
      end
      wgp_pkg::S_CHILD_TYPE: begin
        if (acc) begin
          if (kind) state_next = wgp_pkg::S_MARK;
          else if (sts.bi3) state_next = wgp_pkg::S_HDR_CHILD;
        end
      end
      wgp_pkg::S_COUNT: begin
        if (acc) begin
          if (kind) state_next = wgp_pkg::S_MARK;
          else if (sts.bi3) state_next = wgp_pkg::S_CNT;
        end
      end
      wgp_pkg::S_RING_COUNT: begin
        if (acc) begin
          if (kind) state_next = wgp_pkg::S_MARK;
          else if (sts.bi3) state_next = wgp_pkg::S_RCNT;
        end
      end
      wgp_pkg::S_ORD: begin
        if (acc) begin
          if (kind) state_next = wgp_pkg::S_MARK;
          else if (sts.bi7) state_next = wgp_pkg::S_PT;
        end
      end
      wgp_pkg::S_DONE, wgp_pkg::S_ERR: begin
        if (acc && kind) state_next = wgp_pkg::S_ROOT_ORDER;
      end
      wgp_pkg::S_HDR_ROOT: begin
        if (sts.out_free) begin
          if (sts.lay_bad || sts.type_bad) state_next = wgp_pkg::S_ERR;
          else state_next = sts.base_point ? wgp_pkg::S_ORD : wgp_pkg::S_COUNT;
        end
      end
      wgp_pkg::S_HDR_CHILD: begin
        if (sts.out_free) begin
          if (sts.lay_bad || sts.type_bad || sts.child_bad || sts.mismatch ||
              sts.depth_bad) begin
            state_next = wgp_pkg::S_ERR;
          end else begin
            state_next = sts.base_point ? wgp_pkg::S_ORD : wgp_pkg::S_COUNT;
          end
        end
      end
      wgp_pkg::S_CNT: begin
        if (sts.out_free) begin
          if (sts.cur_type == wgp_pkg::GT_LINE || sts.cur_type == wgp_pkg::GT_CSTR) begin
            if (sts.cur_type == wgp_pkg::GT_CSTR && sts.arc_bad) state_next = wgp_pkg::S_ERR;
            else state_next = sts.cnt_zero ? wgp_pkg::S_FIN : wgp_pkg::S_ORD;
          end else if (sts.cnt_zero) begin
            state_next = wgp_pkg::S_FIN;
          end else begin
            state_next = (sts.cur_type == wgp_pkg::GT_POLY) ? wgp_pkg::S_RING_COUNT
                                                             : wgp_pkg::S_CHILD_ORDER;
          end
        end
      end
      wgp_pkg::S_RCNT: begin
        if (sts.out_free) state_next = sts.cnt_zero ? wgp_pkg::S_RZERO : wgp_pkg::S_ORD;
      end
      wgp_pkg::S_RZERO: begin
        if (sts.out_free) begin
          state_next = sts.left_dec_zero ? wgp_pkg::S_FIN : wgp_pkg::S_RING_COUNT;
        end
      end
      wgp_pkg::S_PT: begin
        if (sts.out_free) begin
          if (!sts.ord_last) state_next = wgp_pkg::S_ORD;
          else if (sts.cur_type == wgp_pkg::GT_POINT) state_next = wgp_pkg::S_FIN;
          else if (sts.cur_type == wgp_pkg::GT_POLY) begin
            state_next = sts.pts_dec_zero ? wgp_pkg::S_RZERO : wgp_pkg::S_ORD;
          end else begin
            state_next = sts.pts_dec_zero ? wgp_pkg::S_FIN : wgp_pkg::S_ORD;
          end
        end
      end
      wgp_pkg::S_FIN: begin
        if (sts.out_free) begin
          if (sts.lvl_zero) state_next = wgp_pkg::S_DONE_EV;
          else state_next = sts.left_dec_zero ? wgp_pkg::S_FIN : wgp_pkg::S_CHILD_ORDER;
        end
      end
      wgp_pkg::S_DONE_EV: begin
        if (sts.out_free) state_next = wgp_pkg::S_DONE;
      end
      wgp_pkg::S_MARK: begin
        if (sts.out_free) state_next = wgp_pkg::S_ROOT_ORDER;
      end
      default: state_next = wgp_pkg::S_ROOT_ORDER;
    endcase
  end

  // commands
  always_comb begin
    cmd      = '0;
    cmd.op   = wgp_pkg::OP_NONE;
    cmd.ev   = wgp_pkg::EV_BEGIN;
    cmd.err  = wgp_pkg::ERR_TRUNC;
    cmd.fire = phase ? acc : sts.out_free;
    case (state)
      wgp_pkg::S_ROOT_ORDER, wgp_pkg::S_CHILD_ORDER: begin
        cmd.op = kind ? wgp_pkg::OP_NONE : wgp_pkg::OP_ORDER;
      end
      wgp_pkg::S_ROOT_TYPE, wgp_pkg::S_CHILD_TYPE, wgp_pkg::S_COUNT,
      wgp_pkg::S_RING_COUNT, wgp_pkg::S_ORD: begin
        cmd.op = kind ? wgp_pkg::OP_NONE : wgp_pkg::OP_TAKE;
      end
      wgp_pkg::S_DONE, wgp_pkg::S_ERR: begin
        cmd.op = kind ? wgp_pkg::OP_REARM : wgp_pkg::OP_NONE;
      end
      wgp_pkg::S_HDR_ROOT: begin
        cmd.op   = wgp_pkg::OP_HDR_ROOT;
        cmd.emit = 1'b1;
        cmd.last = 1'b1;
        if (sts.lay_bad) begin
          cmd.ev  = wgp_pkg::EV_ERROR;
          cmd.err = wgp_pkg::ERR_LAYOUT;
        end else if (sts.type_bad) begin
          cmd.ev  = wgp_pkg::EV_ERROR;
          cmd.err = wgp_pkg::ERR_TYPE;
        end
      end
      wgp_pkg::S_HDR_CHILD: begin
        cmd.op   = wgp_pkg::OP_HDR_CHILD;
        cmd.emit = 1'b1;
        cmd.last = 1'b1;
        if (sts.lay_bad) begin
          cmd.ev  = wgp_pkg::EV_ERROR;
          cmd.err = wgp_pkg::ERR_LAYOUT;
        end else if (sts.type_bad) begin
          cmd.ev  = wgp_pkg::EV_ERROR;
          cmd.err = wgp_pkg::ERR_TYPE;
        end else if (sts.child_bad) begin
          cmd.ev  = wgp_pkg::EV_ERROR;
          cmd.err = wgp_pkg::ERR_CHILD;
        end else if (sts.mismatch) begin
          cmd.ev  = wgp_pkg::EV_ERROR;
          cmd.err = wgp_pkg::ERR_MISMATCH;
        end else if (sts.depth_bad) begin
          cmd.ev  = wgp_pkg::EV_ERROR;
          cmd.err = wgp_pkg::ERR_DEPTH;
        end
      end
      wgp_pkg::S_CNT: begin
        cmd.op = wgp_pkg::OP_CNT;
        if (sts.cur_type == wgp_pkg::GT_CSTR && sts.arc_bad) begin
          cmd.emit = 1'b1;
          cmd.last = 1'b1;
          cmd.ev   = wgp_pkg::EV_ERROR;
          cmd.err  = wgp_pkg::ERR_ARC;
        end
      end
      wgp_pkg::S_RCNT: begin
        cmd.op   = wgp_pkg::OP_RCNT;
        cmd.emit = 1'b1;
        cmd.last = !sts.cnt_zero;
      end
      wgp_pkg::S_RZERO: begin
        cmd.op   = wgp_pkg::OP_RZERO;
        cmd.emit = 1'b1;
        cmd.ev   = wgp_pkg::EV_END;
        cmd.last = !sts.left_dec_zero;
      end
      wgp_pkg::S_PT: begin
        cmd.op = wgp_pkg::OP_PT;
        cmd.ev = wgp_pkg::EV_POINT;
        if (sts.ord_last) begin
          if (sts.cur_type == wgp_pkg::GT_POINT) begin
            cmd.emit = !sts.all_nan;
          end else begin
            cmd.emit = 1'b1;
            cmd.last = !sts.pts_dec_zero;
          end
        end
      end
      wgp_pkg::S_FIN: begin
        cmd.op   = wgp_pkg::OP_FIN;
        cmd.emit = 1'b1;
        cmd.ev   = wgp_pkg::EV_END;
        cmd.last = !sts.lvl_zero && !sts.left_dec_zero;
      end
      wgp_pkg::S_DONE_EV: begin
        cmd.op   = wgp_pkg::OP_DONE;
        cmd.emit = 1'b1;
        cmd.ev   = wgp_pkg::EV_DONE;
        cmd.last = 1'b1;
      end
      wgp_pkg::S_MARK: begin
        cmd.op   = wgp_pkg::OP_MARK;
        cmd.emit = 1'b1;
        cmd.ev   = wgp_pkg::EV_ERROR;
        cmd.err  = wgp_pkg::ERR_TRUNC;
        cmd.last = 1'b1;
      end
      default: cmd.op = wgp_pkg::OP_NONE;
    endcase
  end

endmodule
`default_nettype wire

// ===== src/wgp_dp.sv =====
`default_nettype none
module wgp_dp (
  input  wire logic          clk,
  input  wire logic          rst,
  input  wire wgp_pkg::cmd_t cmd,
  output wgp_pkg::sts_t      sts,
  input  wire logic [7:0]    data_byte,
  input  wire logic          cfg_we,
  input  wire logic          cfg_index,
  input  wire logic          cfg_data,
  output logic               res_valid,
  input  wire logic          res_stall,
  output logic [2:0]         event_res,
  output logic [3:0]         geometry_type,
  output logic [1:0]         coord_layout,
  output logic [3:0]         nesting_level,
  output logic [63:0]        ord_x,
  output logic [63:0]        ord_y,
  output logic [63:0]        ord_third,
  output logic [63:0]        ord_fourth,
  output logic [2:0]         error_code,
  output logic               last
);

  localparam int LVW = wgp_pkg::LVW;

  logic              alt_dialect;
  logic              alt_le;
  logic              little;
  logic [1:0]        layout;
  logic [2:0]        bi;
  logic [63:0]       asm_reg;
  logic [63:0]       asm_next;
  logic [LVW-1:0]    level;
  logic [31:0]       pts;
  logic [1:0]        oi;
  logic [63:0]       obuf [3];
  logic [3:0]        ftype [wgp_pkg::MAX_DEPTH];
  logic [31:0]       fleft [wgp_pkg::MAX_DEPTH];

  logic [31:0]       t;
  logic [31:0]       tt;
  logic [1:0]        m;
  logic [31:0]       mk;
  logic [31:0]       base32;
  logic [3:0]        base4;
  logic [3:0]        cur_type;
  logic [LVW-1:0]    la;
  logic [31:0]       left_rd;
  logic [LVW:0]      lvl1;
  logic [2:0]        cs;
  logic [63:0]       o0, o1, o2, o3;
  logic              load;

  logic [3:0]        f_gt;
  logic [1:0]        f_lay;
  logic [3:0]        f_lv;
  logic [63:0]       f_o0, f_o1, f_o2, f_o3;
  logic [2:0]        f_err;

  assign asm_next = little ? (asm_reg | (64'(data_byte) << {bi, 3'b000}))
                           : {asm_reg[55:0], data_byte};

  // type word with the sign-bit repair folded in
  assign t  = asm_reg[31:0];
  assign tt = ((t & wgp_pkg::SIGN_BIT) != 32'd0) ? ((t & wgp_pkg::LOW_MASK) + wgp_pkg::L1000)
                                                 : t;
  always_comb begin
    if (tt >= wgp_pkg::L3000) begin
      m  = 2'd3;
      mk = wgp_pkg::L3000;
    end else if (tt >= wgp_pkg::L2000) begin
      m  = 2'd2;
      mk = wgp_pkg::L2000;
    end else if (tt >= wgp_pkg::L1000) begin
      m  = 2'd1;
      mk = wgp_pkg::L1000;
    end else begin
      m  = 2'd0;
      mk = 32'd0;
    end
  end
  assign base32 = tt - mk;
  assign base4  = base32[3:0];

  assign cur_type = ftype[level];
  assign la       = (cmd.op == wgp_pkg::OP_FIN) ? (level - LVW'(1)) : level;
  assign left_rd  = fleft[la];
  assign lvl1     = {1'b0, level} + (LVW+1)'(1);
  assign cs       = (layout == 2'd0) ? 3'd2 : ((layout == 2'd3) ? 3'd4 : 3'd3);

  assign o0 = (oi == 2'd0) ? asm_reg : obuf[0];
  assign o1 = (oi == 2'd1) ? asm_reg : obuf[1];
  assign o2 = (cs > 3'd2) ? ((oi == 2'd2) ? asm_reg : obuf[2]) : 64'd0;
  assign o3 = (cs > 3'd3) ? asm_reg : 64'd0;

  always_comb begin
    sts               = '0;
    sts.out_free      = !res_valid || !res_stall;
    sts.bi3           = (bi == 3'd3);
    sts.bi7           = (bi == 3'd7);
    sts.lay_bad       = (tt >= wgp_pkg::L4000);
    sts.type_bad      = (base32 == 32'd0) || (base32 > 32'd10);
    sts.base_point    = (base4 == wgp_pkg::GT_POINT);
    sts.child_bad     = !wgp_pkg::child_ok(cur_type, base4);
    sts.mismatch      = (m != layout);
    sts.depth_bad     = (lvl1 >= (LVW+1)'(wgp_pkg::MAX_DEPTH));
    sts.cnt_zero      = (t == 32'd0);
    sts.arc_bad       = (t != 32'd0) && ((t < 32'd3) || !t[0]);
    sts.lvl_zero      = (level == '0);
    sts.left_dec_zero = (left_rd == 32'd1);
    sts.pts_dec_zero  = (pts == 32'd1);
    sts.ord_last      = (({1'b0, oi} + 3'd1) >= cs);
    sts.all_nan       = wgp_pkg::is_nan(o0) && wgp_pkg::is_nan(o1) &&
                        ((cs < 3'd3) || wgp_pkg::is_nan(o2)) &&
                        ((cs < 3'd4) || wgp_pkg::is_nan(o3));
    sts.cur_type      = cur_type;
  end

  // result fields
  always_comb begin
    f_gt  = 4'd0;
    f_lay = 2'd0;
    f_lv  = 4'd0;
    f_o0  = 64'd0;
    f_o1  = 64'd0;
    f_o2  = 64'd0;
    f_o3  = 64'd0;
    f_err = (cmd.ev == wgp_pkg::EV_ERROR) ? cmd.err : 3'd0;
    if (cmd.ev == wgp_pkg::EV_BEGIN || cmd.ev == wgp_pkg::EV_END ||
        cmd.ev == wgp_pkg::EV_POINT) begin
      f_lay = layout;
      case (cmd.op)
        wgp_pkg::OP_HDR_ROOT: begin
          f_gt  = base4;
          f_lay = m;
        end
        wgp_pkg::OP_HDR_CHILD: begin
          f_gt = base4;
          f_lv = 4'(lvl1);
        end
        wgp_pkg::OP_RCNT, wgp_pkg::OP_RZERO: begin
          f_gt = wgp_pkg::GT_RING;
          f_lv = 4'(lvl1);
        end
        wgp_pkg::OP_PT: begin
          f_gt = (cur_type == wgp_pkg::GT_POLY) ? wgp_pkg::GT_RING : cur_type;
          f_lv = (cur_type == wgp_pkg::GT_POLY) ? 4'(lvl1) : 4'(level);
          f_o0 = o0;
          f_o1 = o1;
          f_o2 = o2;
          f_o3 = o3;
        end
        wgp_pkg::OP_FIN: begin
          f_gt = cur_type;
          f_lv = 4'(level);
        end
        default: f_gt = 4'd0;
      endcase
    end
  end

  assign load = cmd.fire && cmd.emit;

  always_ff @(posedge clk) begin
    if (rst) begin
      res_valid <= 1'b0;
    end else if (load) begin
      res_valid <= 1'b1;
    end else if (!res_stall) begin
      res_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (load) begin
      event_res     <= cmd.ev;
      geometry_type <= f_gt;
      coord_layout  <= f_lay;
      nesting_level <= f_lv;
      ord_x         <= f_o0;
      ord_y         <= f_o1;
      ord_third     <= f_o2;
      ord_fourth    <= f_o3;
      error_code    <= f_err;
      last          <= cmd.last;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      alt_dialect <= 1'b0;
      alt_le      <= 1'b0;
    end else if (cfg_we) begin
      case (cfg_index)
        wgp_pkg::CFG_ALT_DIALECT: alt_dialect <= cfg_data;
        wgp_pkg::CFG_ALT_LE:      alt_le      <= cfg_data;
        default:                  alt_le      <= alt_le;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      little  <= 1'b0;
      layout  <= 2'd0;
      bi      <= 3'd0;
      asm_reg <= 64'd0;
      level   <= '0;
      pts     <= 32'd0;
      oi      <= 2'd0;
    end else if (cmd.fire) begin
      case (cmd.op)
        wgp_pkg::OP_ORDER: begin
          little  <= alt_dialect ? alt_le : (data_byte != 8'd0);
          bi      <= 3'd0;
          asm_reg <= 64'd0;
        end
        wgp_pkg::OP_TAKE: begin
          asm_reg <= asm_next;
          bi      <= bi + 3'd1;
        end
        wgp_pkg::OP_REARM, wgp_pkg::OP_MARK: begin
          bi      <= 3'd0;
          asm_reg <= 64'd0;
          level   <= '0;
          pts     <= 32'd0;
          oi      <= 2'd0;
        end
        wgp_pkg::OP_HDR_ROOT: begin
          bi      <= 3'd0;
          asm_reg <= 64'd0;
          if (!sts.lay_bad && !sts.type_bad) begin
            layout <= m;
            level  <= '0;
            oi     <= 2'd0;
          end
        end
        wgp_pkg::OP_HDR_CHILD: begin
          bi      <= 3'd0;
          asm_reg <= 64'd0;
          if (!sts.lay_bad && !sts.type_bad && !sts.child_bad && !sts.mismatch &&
              !sts.depth_bad) begin
            level <= lvl1[LVW-1:0];
            oi    <= 2'd0;
          end
        end
        wgp_pkg::OP_CNT: begin
          bi      <= 3'd0;
          asm_reg <= 64'd0;
          if ((cur_type == wgp_pkg::GT_LINE || cur_type == wgp_pkg::GT_CSTR) &&
              !(cur_type == wgp_pkg::GT_CSTR && sts.arc_bad)) begin
            pts <= t;
            oi  <= 2'd0;
          end
        end
        wgp_pkg::OP_RCNT: begin
          bi      <= 3'd0;
          asm_reg <= 64'd0;
          pts     <= t;
          oi      <= 2'd0;
        end
        wgp_pkg::OP_PT: begin
          bi      <= 3'd0;
          asm_reg <= 64'd0;
          if (!sts.ord_last) begin
            oi <= oi + 2'd1;
          end else begin
            oi <= 2'd0;
            if (cur_type != wgp_pkg::GT_POINT) pts <= pts - 32'd1;
          end
        end
        wgp_pkg::OP_FIN: begin
          if (level != '0) level <= level - LVW'(1);
        end
        default: bi <= bi;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.fire && cmd.op == wgp_pkg::OP_PT && !sts.ord_last && oi != 2'd3) begin
      obuf[oi] <= asm_reg;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.fire) begin
      case (cmd.op)
        wgp_pkg::OP_HDR_ROOT: begin
          if (!sts.lay_bad && !sts.type_bad) ftype[0] <= base4;
        end
        wgp_pkg::OP_HDR_CHILD: begin
          if (!sts.lay_bad && !sts.type_bad && !sts.child_bad && !sts.mismatch &&
              !sts.depth_bad) begin
            ftype[lvl1[LVW-1:0]] <= base4;
          end
        end
        default: ftype[0] <= ftype[0];
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.fire) begin
      case (cmd.op)
        wgp_pkg::OP_CNT: begin
          if (cur_type != wgp_pkg::GT_LINE && cur_type != wgp_pkg::GT_CSTR) begin
            fleft[level] <= t;
          end
        end
        wgp_pkg::OP_RZERO: fleft[la] <= left_rd - 32'd1;
        wgp_pkg::OP_FIN: begin
          if (level != '0) fleft[la] <= left_rd - 32'd1;
        end
        default: fleft[la] <= fleft[la];
      endcase
    end
  end

  a_load_free: assert property (@(posedge clk) disable iff (rst)
    (cmd.fire && cmd.emit) |-> (!res_valid || !res_stall))
    else $error("result loaded over a stalled result");

  a_oi_range: assert property (@(posedge clk) disable iff (rst)
    ({1'b0, oi} < cs))
    else $error("ordinate index beyond coordinate size");

  a_ctrl_zero: assert property (@(posedge clk) disable iff (rst)
    (res_valid && (event_res == wgp_pkg::EV_ERROR || event_res == wgp_pkg::EV_DONE)) |->
    (geometry_type == 4'd0 && nesting_level == 4'd0 && ord_x == 64'd0))
    else $error("error or done result carries geometry fields");

endmodule
`default_nettype wire
